[rtl/pwd_pkg.sv]
package pwd_pkg;

    localparam int FIFO_DEPTH_DEF = 16;
    localparam int DATA_W         = 8;
    localparam int FILL_W         = 5;
    localparam int THR_W          = 6;
    localparam int CNT_W          = 3;
    localparam int BITS_PER_BYTE  = 8;
    localparam int APB_ADDR_W     = 3;
    localparam int APB_DATA_W     = 32;

    localparam logic [DATA_W-1:0] SYNC_RESET = 8'h80;

    // register index, taken from paddr[2]
    localparam logic REG_SYNC_THR = 1'b0;

    typedef enum logic {
        OP_EDGE = 1'b0,
        OP_READ = 1'b1
    } t_op;

    // per-transaction result info travelling beside the memory read
    typedef struct packed {
        logic              read_valid;
        logic [FILL_W-1:0] fill_count;
    } t_result;

endpackage

[rtl/pwd_if.sv]
interface pwd_in_if;
    logic                      valid;
    logic                      ready;
    logic                      operation;
    logic [pwd_pkg::DATA_W-1:0] pulse_length;

    modport source (output valid, output operation, output pulse_length, input ready);
    modport sink   (input valid, input operation, input pulse_length, output ready);
endinterface

interface pwd_out_if;
    logic                       valid;
    logic                       ready;
    logic [pwd_pkg::DATA_W-1:0] read_byte;
    logic                       read_valid;
    logic [pwd_pkg::FILL_W-1:0] fill_count;

    modport source (output valid, output read_byte, output read_valid, output fill_count,
                    input ready);
    modport sink   (input valid, input read_byte, input read_valid, input fill_count,
                    output ready);
endinterface

[rtl/pulse_width_demodulator_fifo.sv]
// pulse width demodulator with sync detection and a byte fifo
//
// input channel i_in_ch: one transaction is either an edge event carrying the
// measured pulse length (operation 0) or a host read of one byte (operation 1).
// output channel o_out_ch: exactly one result transaction per input, in order,
// with the popped byte, a flag telling whether a byte was popped, and the fifo
// fill level after that input.
// each result passes through the memory stage (the synchronous byte memory
// read) and then the output register before it appears on o_out_ch.
// throughput: one transaction per cycle unless the receiver stalls, set by
// the single read-modify-write of the index and shifter state and the read port.
// the apb port holds sync_threshold at address 0; write it only while idle.
// reset (synchronous, active low) clears indices, shifter, bit count, bit
// threshold and sets sync_threshold to 0x80; the byte memory is not cleared.
// when the receiver stalls, the output register and the memory stage hold
// and i_in_ch.ready drops once both are occupied; nothing is lost.
module pulse_width_demodulator_fifo #(
    parameter int FIFO_DEPTH = pwd_pkg::FIFO_DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    pwd_in_if.sink                           i_in_ch,
    pwd_out_if.source                        o_out_ch,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [pwd_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [pwd_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [pwd_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready
);

    localparam int AW = $clog2(FIFO_DEPTH);

    logic [pwd_pkg::DATA_W-1:0] sync_thr;
    logic                       accept;
    logic                       s1_adv;
    logic                       wen, ren;
    logic [AW-1:0]              waddr, raddr;
    logic [pwd_pkg::DATA_W-1:0] wdata, rdata;
    pwd_pkg::t_result           result;

    logic                       r_s1_v;
    pwd_pkg::t_result           r_s1_res;
    logic                       r_out_v;
    logic [pwd_pkg::DATA_W-1:0] r_out_byte;
    pwd_pkg::t_result           r_out_res;

    assign s1_adv        = !r_out_v || o_out_ch.ready;
    assign i_in_ch.ready = !r_s1_v || s1_adv;
    assign accept        = i_in_ch.valid && i_in_ch.ready;

    pwd_regs u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_sync_thr (sync_thr)
    );

    pwd_demod #(
        .FIFO_DEPTH (FIFO_DEPTH),
        .AW         (AW)
    ) u_demod (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_operation    (i_in_ch.operation),
        .i_pulse_length (i_in_ch.pulse_length),
        .i_sync_thr     (sync_thr),
        .o_wen          (wen),
        .o_waddr        (waddr),
        .o_wdata        (wdata),
        .o_ren          (ren),
        .o_raddr        (raddr),
        .o_result       (result)
    );

    pwd_mem #(
        .DEPTH (FIFO_DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_wen   (wen),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_ren   (ren),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // memory stage; read data stays put until this stage moves on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (i_in_ch.ready) begin
            r_s1_v <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_res <= result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (s1_adv) begin
            r_out_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_v) begin
            r_out_res  <= r_s1_res;
            r_out_byte <= r_s1_res.read_valid ? rdata : '0;
        end
    end

    assign o_out_ch.valid      = r_out_v;
    assign o_out_ch.read_byte  = r_out_byte;
    assign o_out_ch.read_valid = r_out_res.read_valid;
    assign o_out_ch.fill_count = r_out_res.fill_count;

endmodule

[rtl/pwd_regs.sv]
module pwd_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [pwd_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [pwd_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [pwd_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready,
    output logic [pwd_pkg::DATA_W-1:0]       o_sync_thr
);

    logic [pwd_pkg::DATA_W-1:0] r_sync_thr;
    logic                       sel_sync;

    assign sel_sync = (paddr[2] == pwd_pkg::REG_SYNC_THR);
    assign pready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_thr <= pwd_pkg::SYNC_RESET;
        end else if (psel && penable && pwrite && sel_sync) begin
            r_sync_thr <= pwdata[pwd_pkg::DATA_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (sel_sync) begin
            prdata = {{(pwd_pkg::APB_DATA_W-pwd_pkg::DATA_W){1'b0}}, r_sync_thr};
        end
    end

    assign o_sync_thr = r_sync_thr;

endmodule

[rtl/pwd_mem.sv]
module pwd_mem #(
    parameter int DEPTH = pwd_pkg::FIFO_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                       i_clk,
    input  logic                       i_wen,
    input  logic [AW-1:0]              i_waddr,
    input  logic [pwd_pkg::DATA_W-1:0] i_wdata,
    input  logic                       i_ren,
    input  logic [AW-1:0]              i_raddr,
    output logic [pwd_pkg::DATA_W-1:0] o_rdata
);

    logic [pwd_pkg::DATA_W-1:0] r_mem [DEPTH];
    logic [pwd_pkg::DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wen) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // holds its value between reads
    always_ff @(posedge i_clk) begin
        if (i_ren) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/pwd_demod.sv]
module pwd_demod #(
    parameter int FIFO_DEPTH = pwd_pkg::FIFO_DEPTH_DEF,
    parameter int AW         = $clog2(FIFO_DEPTH)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_accept,
    input  logic                       i_operation,
    input  logic [pwd_pkg::DATA_W-1:0] i_pulse_length,
    input  logic [pwd_pkg::DATA_W-1:0] i_sync_thr,
    output logic                       o_wen,
    output logic [AW-1:0]              o_waddr,
    output logic [pwd_pkg::DATA_W-1:0] o_wdata,
    output logic                       o_ren,
    output logic [AW-1:0]              o_raddr,
    output pwd_pkg::t_result           o_result
);

    localparam int IW  = $clog2(2 * FIFO_DEPTH);
    localparam int LVW = (IW + 1 > pwd_pkg::FILL_W) ? IW + 1 : pwd_pkg::FILL_W;

    logic [IW-1:0]                r_wr_idx, n_wr_idx;
    logic [IW-1:0]                r_rd_idx, n_rd_idx;
    logic [pwd_pkg::CNT_W-1:0]    r_bit_cnt, n_bit_cnt;
    logic [pwd_pkg::THR_W-1:0]    r_bit_thr, n_bit_thr;
    logic [pwd_pkg::DATA_W-1:0]   r_shift, n_shift;
    logic [LVW-1:0]               level_now, level_next;
    logic                         data_bit;
    logic                         pop;

    function automatic logic [IW-1:0] idx_inc(input logic [IW-1:0] idx);
        idx_inc = (idx == IW'(2 * FIFO_DEPTH - 1)) ? '0 : idx + 1'b1;
    endfunction

    function automatic logic [AW-1:0] idx_slot(input logic [IW-1:0] idx);
        logic [IW-1:0] s;
        s = (idx >= IW'(FIFO_DEPTH)) ? idx - IW'(FIFO_DEPTH) : idx;
        idx_slot = s[AW-1:0];
    endfunction

    // occupancy, indices wrap at twice the depth
    function automatic logic [LVW-1:0] level(input logic [IW-1:0] w, input logic [IW-1:0] r);
        logic [LVW-1:0] d;
        d = LVW'(w) - LVW'(r);
        if (w < r) begin
            d = d + LVW'(2 * FIFO_DEPTH);
        end
        level = d;
    endfunction

    assign level_now  = level(r_wr_idx, r_rd_idx);
    assign level_next = level(n_wr_idx, n_rd_idx);
    assign data_bit   = (i_pulse_length >= {2'b00, r_bit_thr});

    always_comb begin
        n_wr_idx  = r_wr_idx;
        n_rd_idx  = r_rd_idx;
        n_bit_cnt = r_bit_cnt;
        n_bit_thr = r_bit_thr;
        n_shift   = r_shift;
        o_wen     = 1'b0;
        o_ren     = 1'b0;
        pop       = 1'b0;
        if (i_accept) begin
            if (i_operation == pwd_pkg::OP_READ) begin
                if (level_now != '0) begin
                    o_ren    = 1'b1;
                    pop      = 1'b1;
                    n_rd_idx = idx_inc(r_rd_idx);
                end
            end else if (i_pulse_length > i_sync_thr) begin
                n_bit_thr = i_pulse_length[pwd_pkg::DATA_W-1:2];
                n_bit_cnt = '0;
            end else begin
                n_shift   = {data_bit, r_shift[pwd_pkg::DATA_W-1:1]};
                n_bit_cnt = r_bit_cnt + 1'b1;
                if (r_bit_cnt == pwd_pkg::CNT_W'(pwd_pkg::BITS_PER_BYTE - 1)
                        && level_now < LVW'(FIFO_DEPTH)) begin
                    o_wen    = 1'b1;
                    n_wr_idx = idx_inc(r_wr_idx);
                end
            end
        end
    end

    // a write lands in memory before any later pop can read that slot
    assign o_waddr  = idx_slot(r_wr_idx);
    assign o_wdata  = n_shift;
    assign o_raddr  = idx_slot(r_rd_idx);
    assign o_result = '{read_valid: pop, fill_count: level_next[pwd_pkg::FILL_W-1:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_idx  <= '0;
            r_rd_idx  <= '0;
            r_bit_cnt <= '0;
            r_bit_thr <= '0;
            r_shift   <= '0;
        end else begin
            r_wr_idx  <= n_wr_idx;
            r_rd_idx  <= n_rd_idx;
            r_bit_cnt <= n_bit_cnt;
            r_bit_thr <= n_bit_thr;
            r_shift   <= n_shift;
        end
    end

endmodule

[rtl/pwd_checker.sv]
module pwd_checker #(
    parameter int FIFO_DEPTH = pwd_pkg::FIFO_DEPTH_DEF
) (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic [pwd_pkg::DATA_W-1:0] i_read_byte,
    input logic                       i_read_valid,
    input logic [pwd_pkg::FILL_W-1:0] i_fill_count
);

    // no result right after reset
    a_idle_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // a result without a popped byte carries a zero byte
    a_zero_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_read_valid) |-> (i_read_byte == '0))
        else $error("nonzero byte without a pop");

    // a pop leaves room for at least one byte
    a_pop_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_read_valid && (FIFO_DEPTH < 32))
            |-> (i_fill_count < pwd_pkg::FILL_W'(FIFO_DEPTH)))
        else $error("fill level too high after a pop");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_read_byte)
            && $stable(i_read_valid) && $stable(i_fill_count)))
        else $error("result changed while stalled");

endmodule

bind pulse_width_demodulator_fifo pwd_checker #(
    .FIFO_DEPTH (FIFO_DEPTH)
) u_pwd_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out_ch.valid),
    .i_out_ready  (o_out_ch.ready),
    .i_read_byte  (o_out_ch.read_byte),
    .i_read_valid (o_out_ch.read_valid),
    .i_fill_count (o_out_ch.fill_count)
);
